### hdl/sfla_pkg.sv
// ---------------------------------------------------------------------------
// sfla_pkg
// Shared types, constants and helpers of the size-class free-list allocator.
// ---------------------------------------------------------------------------
`default_nettype none
package sfla_pkg;
   localparam int NUM_CLASSES = 12;
   localparam int POOL_CHUNKS = 8;
   localparam int HDR_BYTES   = 16;
   localparam int TOP_BYTES   = (1 << (NUM_CLASSES + 4)) - HDR_BYTES;
   localparam int CHUNK_BYTES = 2 * (TOP_BYTES + HDR_BYTES);
   localparam int FIT_CHUNKS  = 1048576 / CHUNK_BYTES;
   localparam int CHUNK_LIMIT = (POOL_CHUNKS < FIT_CHUNKS) ? POOL_CHUNKS : FIT_CHUNKS;
   localparam int CHUNK_IDX   = CHUNK_BYTES / HDR_BYTES;
   localparam int SECOND_IDX  = (TOP_BYTES + HDR_BYTES) / HDR_BYTES;

   typedef logic [3:0]  class_idx_type;
   typedef logic [15:0] blk_idx_type;
   typedef logic [16:0] link_type;

   typedef enum logic [1:0] {
      MODE_ALLOC = 2'd0,
      MODE_FREE  = 2'd1,
      MODE_QUERY = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_ZERO  = 2'd1,
      STAT_LARGE = 2'd2,
      STAT_OOM   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCAN, ST_POP, ST_TAIL, ST_CARVE0, ST_CARVE1, ST_READ, ST_FILE, ST_DONE
   } state_type;

   typedef struct packed {
      logic          hit;
      class_idx_type cls;
      logic [15:0]   tail;
      logic [15:0]   bytes_left;
   } split_type;

   function automatic logic [15:0] class_bytes(input class_idx_type i);
      logic [16:0] v;
      v = (17'd1 << (5'(i) + 5'd5)) - 17'd16;
      return v[15:0];
   endfunction
endpackage
`default_nettype wire

### hdl/sfla_split.sv
// ---------------------------------------------------------------------------
// sfla_split
// Picks the largest class-sized tail that can be cut from a popped block.
// ---------------------------------------------------------------------------
`default_nettype none
module sfla_split (
   input  wire logic [15:0]        block_bytes,
   input  wire logic [15:0]        req_bytes,
   output sfla_pkg::split_type     split
);
   import sfla_pkg::*;

   always_comb begin
      logic [17:0] need;
      split = '0;
      // ascending scan: the largest fitting tail wins
      for (int j = 0; j < NUM_CLASSES; j++) begin
         need = {2'b0, req_bytes} + {2'b0, class_bytes(4'(j))} + 18'd32;
         if ({2'b0, block_bytes} >= need) begin
            split.hit        = 1'b1;
            split.cls        = 4'(j);
            split.tail       = class_bytes(4'(j));
            split.bytes_left = block_bytes - class_bytes(4'(j)) - 16'd16;
         end
      end
   end
endmodule
`default_nettype wire

### hdl/size_class_free_list_allocator_unit.sv
// ---------------------------------------------------------------------------
// size_class_free_list_allocator_unit
// Segregated free-list allocator with LIFO lists per size class.
// ---------------------------------------------------------------------------
// Free/query: ST_READ, ST_FILE, ST_DONE (null address: ST_DONE only). Alloc:
// ST_SCAN, ST_POP, ST_TAIL if a tail is cut, ST_DONE; a reject goes to ST_DONE,
// a carve adds ST_CARVE0, ST_CARVE1 and a rescan. ST_DONE waits while the last
// word is not taken on rsp_tready. One request at a time; the next word is
// accepted in the cycle its result goes valid. Dependent registered reads of
// the link and size memories set the rate. Reset clears list heads, chunk count
// and control; the memories hold no reset and are defined only where written.
`default_nettype none
module size_class_free_list_allocator_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,  // mode[1:0], alloc_size[33:2], user_address[53:34]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata   // result_address[19:0], usable_bytes[35:20], status[37:36]
);
   import sfla_pkg::*;

   state_type     state_ff, state_in;
   logic [1:0]    mode_ff, mode_in;
   logic [15:0]   size_ff, size_in;
   blk_idx_type   idx_ff, idx_in;
   class_idx_type cls_ff, cls_in;
   class_idx_type tcls_ff, tcls_in;
   blk_idx_type   tidx_ff, tidx_in;
   logic [15:0]   tail_ff, tail_in;
   logic [6:0]    chunks_ff, chunks_in;
   link_type      head_ff [NUM_CLASSES];
   link_type      head_in [NUM_CLASSES];
   logic [19:0]   res_addr_ff, res_addr_in;
   logic [15:0]   res_use_ff, res_use_in;
   logic [1:0]    res_stat_ff, res_stat_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [39:0]   rsp_data_ff, rsp_data_in;

   link_type      link_mem  [65536];
   logic [15:0]   bytes_mem [65536];
   blk_idx_type   rd_addr;
   link_type      link_rd_ff;
   logic [15:0]   bytes_rd_ff;
   logic          link_we, bytes_we;
   blk_idx_type   link_wa, bytes_wa;
   link_type      link_wd;
   logic [15:0]   bytes_wd;

   logic          accept;
   logic          hit;
   class_idx_type hit_cls;
   logic          fcls_ok;
   class_idx_type fcls;
   logic          slot_free;
   blk_idx_type   idx0, idx1;
   logic [19:0]   thdr;
   split_type     split;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign idx0       = 16'(32'(chunks_ff) * CHUNK_IDX);
   assign idx1       = idx0 + 16'(SECOND_IDX);
   assign thdr       = {idx_ff, 4'b0} + 20'd16 + {4'b0, split.bytes_left};

   sfla_split u_split (
      .block_bytes (bytes_rd_ff),
      .req_bytes   (size_ff),
      .split       (split)
   );

   // first non-empty class that fits, lowest wins
   always_comb begin
      hit     = 1'b0;
      hit_cls = '0;
      for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
         if (class_bytes(4'(i)) >= size_ff && head_ff[i][16]) begin
            hit     = 1'b1;
            hit_cls = 4'(i);
         end
      end
   end

   // largest class not above the block's size
   always_comb begin
      fcls_ok = 1'b0;
      fcls    = '0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
         if (class_bytes(4'(i)) <= bytes_rd_ff) begin
            fcls_ok = 1'b1;
            fcls    = 4'(i);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_tdata[1:0])
                  MODE_ALLOC: begin
                     if (req_tdata[33:2] == 32'd0 || req_tdata[33:2] > 32'(TOP_BYTES)) begin
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  MODE_FREE, MODE_QUERY: begin
                     state_in = (req_tdata[53:34] == 20'd0) ? ST_DONE : ST_READ;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_SCAN: begin
            if (hit) begin
               state_in = ST_POP;
            end else if (chunks_ff < 7'(CHUNK_LIMIT)) begin
               state_in = ST_CARVE0;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_POP:    state_in = split.hit ? ST_TAIL : ST_DONE;
         ST_TAIL:   state_in = ST_DONE;
         ST_CARVE0: state_in = ST_CARVE1;
         ST_CARVE1: state_in = ST_SCAN;
         ST_READ:   state_in = ST_FILE;
         ST_FILE:   state_in = ST_DONE;
         ST_DONE:   state_in = slot_free ? ST_IDLE : ST_DONE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mode_in      = mode_ff;
      size_in      = size_ff;
      idx_in       = idx_ff;
      cls_in       = cls_ff;
      tcls_in      = tcls_ff;
      tidx_in      = tidx_ff;
      tail_in      = tail_ff;
      chunks_in    = chunks_ff;
      head_in      = head_ff;
      res_addr_in  = res_addr_ff;
      res_use_in   = res_use_ff;
      res_stat_in  = res_stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rd_addr      = idx_ff;
      link_we      = 1'b0;
      link_wa      = idx_ff;
      link_wd      = '0;
      bytes_we     = 1'b0;
      bytes_wa     = idx_ff;
      bytes_wd     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in     = req_tdata[1:0];
               size_in     = req_tdata[17:2];
               idx_in      = 16'((req_tdata[53:34] - 20'd16) >> 4);
               res_addr_in = '0;
               res_use_in  = '0;
               res_stat_in = STAT_OK;
               if (req_tdata[1:0] == MODE_ALLOC) begin
                  if (req_tdata[33:2] == 32'd0) begin
                     res_stat_in = STAT_ZERO;
                  end else if (req_tdata[33:2] > 32'(TOP_BYTES)) begin
                     res_stat_in = STAT_LARGE;
                  end
               end
            end
         end
         ST_SCAN: begin
            rd_addr = head_ff[hit_cls][15:0];
            idx_in  = head_ff[hit_cls][15:0];
            cls_in  = hit_cls;
            if (!hit && chunks_ff >= 7'(CHUNK_LIMIT)) begin
               res_stat_in = STAT_OOM;
            end
         end
         ST_POP: begin
            head_in[cls_ff] = link_rd_ff;
            res_addr_in     = {idx_ff, 4'b0} + 20'd16;
            if (split.hit) begin
               bytes_we   = 1'b1;
               bytes_wd   = split.bytes_left;
               res_use_in = split.bytes_left;
               tidx_in    = thdr[19:4];
               tcls_in    = split.cls;
               tail_in    = split.tail;
            end else begin
               res_use_in = bytes_rd_ff;
            end
         end
         ST_TAIL: begin
            bytes_we         = 1'b1;
            bytes_wa         = tidx_ff;
            bytes_wd         = tail_ff;
            link_we          = 1'b1;
            link_wa          = tidx_ff;
            link_wd          = head_ff[tcls_ff];
            head_in[tcls_ff] = {1'b1, tidx_ff};
         end
         ST_CARVE0: begin
            bytes_we = 1'b1;
            bytes_wa = idx0;
            bytes_wd = 16'(TOP_BYTES);
            link_we  = 1'b1;
            link_wa  = idx0;
            link_wd  = head_ff[NUM_CLASSES-1];
            head_in[NUM_CLASSES-1] = {1'b1, idx0};
         end
         ST_CARVE1: begin
            bytes_we  = 1'b1;
            bytes_wa  = idx1;
            bytes_wd  = 16'(TOP_BYTES);
            link_we   = 1'b1;
            link_wa   = idx1;
            link_wd   = head_ff[NUM_CLASSES-1];
            head_in[NUM_CLASSES-1] = {1'b1, idx1};
            chunks_in = chunks_ff + 7'd1;
         end
         ST_READ: begin
            rd_addr = idx_ff;
         end
         ST_FILE: begin
            if (mode_ff == MODE_QUERY) begin
               res_use_in = bytes_rd_ff;
            end else if (fcls_ok) begin
               link_we       = 1'b1;
               link_wa       = idx_ff;
               link_wd       = head_ff[fcls];
               head_in[fcls] = {1'b1, idx_ff};
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b0, res_stat_ff, res_use_ff, res_addr_ff};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chunks_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            head_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         chunks_ff    <= chunks_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      size_ff     <= size_in;
      idx_ff      <= idx_in;
      cls_ff      <= cls_in;
      tcls_ff     <= tcls_in;
      tidx_ff     <= tidx_in;
      tail_ff     <= tail_in;
      res_addr_ff <= res_addr_in;
      res_use_ff  <= res_use_in;
      res_stat_ff <= res_stat_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      link_rd_ff <= link_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (bytes_we) begin
         bytes_mem[bytes_wa] <= bytes_wd;
      end
      bytes_rd_ff <= bytes_mem[rd_addr];
   end
endmodule
`default_nettype wire

### tb/tb_size_class_free_list_allocator_unit.sv
// ---------------------------------------------------------------------------
// tb_size_class_free_list_allocator_unit
// Self-checking bench: requests stream in with random gaps, responses are
// compared against an in-bench allocator model with its own free lists.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_size_class_free_list_allocator_unit;
   import sfla_pkg::*;

   localparam int RANDOM_WORDS = 750;

   // last field in the lowest bits, matching the bus packing
   typedef struct packed {
      logic [19:0] user_address;
      logic [31:0] alloc_size;
      logic [1:0]  mode;
   } request_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] usable_bytes;
      logic [19:0] result_address;
   } response_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [39:0] rsp_tdata;

   size_class_free_list_allocator_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // allocator model state
   logic [16:0] head_m [NUM_CLASSES];
   logic [16:0] link_m [int];
   logic [15:0] size_m [int];
   int          chunks_m;

   request_type  pending_reqs [$];
   response_type expected_rsps [$];
   logic [19:0] live_addrs [$];   // addresses handed out and not yet freed
   logic [19:0] known_addrs [$];  // every address whose header was written
   int          errors = 0;
   bit          calm = 0;         // no idling near the end
   bit          hold_off = 0;
   bit          stim_done = 0;

   initial forever #4 clock = ~clock;

   function automatic int cls_bytes(int i);
      return (1 << (i + 5)) - 16;
   endfunction

   function automatic void file_blk(int idx, int bytes);
      for (int i = NUM_CLASSES - 1; i >= 0; i--)
         if (cls_bytes(i) <= bytes) begin
            link_m[idx] = head_m[i];
            head_m[i] = {1'b1, 16'(idx)};
            return;
         end
   endfunction

   function automatic int rd_size(int idx);
      return size_m.exists(idx) ? int'(size_m[idx]) : 0;
   endfunction

   function automatic bit pop_fit(int want, output int got);
      int idx, bytes, tail, thdr;
      got = 0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
         if (cls_bytes(i) < want || !head_m[i][16]) continue;
         idx = head_m[i][15:0];
         head_m[i] = link_m.exists(idx) ? link_m[idx] : 17'd0;
         bytes = rd_size(idx);
         for (int j = NUM_CLASSES - 1; j >= 0; j--) begin
            tail = cls_bytes(j);
            if (bytes >= want + tail + 32) begin
               bytes -= tail + 16;
               size_m[idx] = 16'(bytes);
               thdr = ((idx << 4) + 16 + bytes) & 20'hFFFFF;
               size_m[thdr >> 4] = 16'(tail);
               known_addrs.push_back(20'(thdr + 16));
               file_blk(thdr >> 4, tail);
               break;
            end
         end
         got = idx;
         return 1;
      end
      return 0;
   endfunction

   function automatic response_type predict_response(request_type r);
      response_type o;
      int idx, got, base, sec;
      bit ok;
      o = '0;
      idx = ((int'(r.user_address) - 16) & 20'hFFFFF) >> 4;
      case (mode_type'(r.mode))
         MODE_ALLOC: begin
            if (r.alloc_size == 0) o.status = STAT_ZERO;
            else if (r.alloc_size > TOP_BYTES) o.status = STAT_LARGE;
            else begin
               ok = pop_fit(int'(r.alloc_size), got);
               if (!ok && chunks_m < CHUNK_LIMIT) begin
                  base = chunks_m * CHUNK_BYTES;
                  sec = base + TOP_BYTES + 16;
                  size_m[base >> 4] = 16'(TOP_BYTES);
                  file_blk(base >> 4, TOP_BYTES);
                  size_m[sec >> 4] = 16'(TOP_BYTES);
                  file_blk(sec >> 4, TOP_BYTES);
                  known_addrs.push_back(20'(base + 16));
                  known_addrs.push_back(20'(sec + 16));
                  chunks_m++;
                  ok = pop_fit(int'(r.alloc_size), got);
               end
               if (ok) begin
                  o.result_address = 20'((got << 4) + 16);
                  o.usable_bytes = size_m[got];
                  live_addrs.push_back(o.result_address);
               end else o.status = STAT_OOM;
            end
         end
         MODE_FREE:  if (r.user_address != 0) file_blk(idx, rd_size(idx));
         MODE_QUERY: if (r.user_address != 0) o.usable_bytes = 16'(rd_size(idx));
         default: ;
      endcase
      return o;
   endfunction

   // driver
   int send_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_rsps.push_back(predict_response(request_type'(req_tdata[53:0])));
            void'(pending_reqs.pop_front());
         end
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 0;
         end else if ((!req_tvalid || req_tready) && !calm && $urandom_range(0, 15) == 0) begin
            send_gap <= $urandom_range(1, 19) - 1;
            req_tvalid <= 0;
         end else if (req_tvalid && !req_tready) begin
            req_tvalid <= 1;
         end else begin
            // the front was just consumed or nothing is offered; offer the next word, if any
            if (pending_reqs.size() > 0) begin
               req_tvalid <= 1;
               req_tdata <= {2'b0, pending_reqs[0]};
            end else req_tvalid <= 0;
         end
      end
   end

   // monitor
   int sink_gap = 0;
   always @(posedge clock) begin
      response_type got, exp;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = response_type'(rsp_tdata[37:0]);
            if (expected_rsps.size() == 0) begin
               $error("response with nothing expected: %h", rsp_tdata);
               errors++;
            end else begin
               exp = expected_rsps.pop_front();
               if (got.result_address !== exp.result_address) begin
                  $error("result_address exp %h got %h", exp.result_address,
                         got.result_address);
                  errors++;
               end
               if (got.usable_bytes !== exp.usable_bytes) begin
                  $error("usable_bytes exp %0d got %0d", exp.usable_bytes,
                         got.usable_bytes);
                  errors++;
               end
               if (got.status !== exp.status) begin
                  $error("status exp %0d got %0d", exp.status, got.status);
                  errors++;
               end
            end
         end
         if (hold_off) rsp_tready <= 0;
         else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            rsp_tready <= 0;
         end else if (!calm && $urandom_range(0, 12) == 0) begin
            sink_gap <= $urandom_range(1, 19) - 1;
            rsp_tready <= 0;
         end else rsp_tready <= 1;
      end
   end

   function automatic request_type mk(mode_type m, logic [31:0] sz, logic [31:0] a);
      request_type r;
      r.mode = m; r.alloc_size = sz; r.user_address = a[19:0];
      return r;
   endfunction

   // pick an address whose header is known, so no unwritten entry is read
   function automatic logic [19:0] pick_known();
      if (known_addrs.size() == 0) return 20'd0;
      return known_addrs[$urandom_range(0, known_addrs.size() - 1)];
   endfunction

   // stimulus; addresses for free/query come from the address lists kept by the
   // in-bench model, which runs as each word is accepted
   initial begin
      int n, sz, k, lcount;
      for (int i = 0; i < NUM_CLASSES; i++) head_m[i] = '0;
      chunks_m = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      // directed words; free/query only use the null address or addresses of blocks that exist
      pending_reqs.push_back(mk(MODE_ALLOC, 0, 20'hFFFFF));
      pending_reqs.push_back(mk(MODE_ALLOC, 32'hFFFFFFFF, 0));
      pending_reqs.push_back(mk(MODE_ALLOC, TOP_BYTES + 1, 0));
      pending_reqs.push_back(mk(MODE_ALLOC, 1, 0));
      pending_reqs.push_back(mk(MODE_ALLOC, TOP_BYTES, 0));
      pending_reqs.push_back(mk(MODE_ALLOC, 16, 0));
      pending_reqs.push_back(mk(MODE_NONE, 32'hFFFFFFFF, 20'hFFFFF));
      pending_reqs.push_back(mk(MODE_FREE, 32'hAAAAAAAA, 0));
      pending_reqs.push_back(mk(MODE_QUERY, 32'h55555555, 0));
      pending_reqs.push_back(mk(MODE_QUERY, 0, 20'h00010));
      pending_reqs.push_back(mk(MODE_QUERY, 0, 20'h0001F)); // low bits ignored
      pending_reqs.push_back(mk(MODE_FREE, 0, 20'h00010));
      pending_reqs.push_back(mk(MODE_FREE, 0, 20'h00010));  // double free
      pending_reqs.push_back(mk(MODE_ALLOC, 17, 0));
      pending_reqs.push_back(mk(MODE_ALLOC, 4000, 0));
      // drain so the live list reflects the directed part
      wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
      // receiver holds off while the sender keeps offering
      for (int i = 0; i < 12; i++) pending_reqs.push_back(mk(MODE_ALLOC, 1 << (i % 12), 0));
      hold_off = 1;
      repeat (300) @(posedge clock);
      hold_off = 0;
      wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
      // random phase in small batches, each drained before the next so the
      // address pool used for free/query stays in sync with the model
      n = 0;
      while (n < RANDOM_WORDS) begin
         if (n > RANDOM_WORDS - 80) calm = 1;
         for (int b = 0; b < 10; b++) begin
            k = $urandom_range(0, 99);
            if (k < 45) begin
               case ($urandom_range(0, 3))
                  0: sz = $urandom_range(1, 64);
                  1: sz = $urandom_range(1, 2048);
                  2: sz = $urandom_range(1, TOP_BYTES);
                  default: sz = $urandom_range(TOP_BYTES - 8, TOP_BYTES + 8);
               endcase
               if ($urandom_range(0, 40) == 0) sz = $urandom; // wide / odd sizes
               pending_reqs.push_back(mk(MODE_ALLOC, sz, $urandom));
            end else if (k < 80 && live_addrs.size() > 0) begin
               lcount = $urandom_range(0, live_addrs.size() - 1);
               pending_reqs.push_back(mk(MODE_FREE, $urandom,
                                         live_addrs[lcount] | 20'($urandom_range(0, 15))));
               live_addrs.delete(lcount);
            end else if (k < 95) begin
               pending_reqs.push_back(mk(MODE_QUERY, $urandom,
                                         $urandom_range(0, 7) == 0 ? 20'd0 : pick_known()));
            end else if (k < 98 && known_addrs.size() > 0) begin
               pending_reqs.push_back(mk(MODE_FREE, $urandom, pick_known())); // stray free
            end else begin
               pending_reqs.push_back(mk(MODE_NONE, $urandom, $urandom));
            end
            n++;
         end
         wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
      end
      stim_done = 1;
      repeat (40) @(posedge clock);
      if (errors == 0 && expected_rsps.size() == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   initial begin
      #5ms;
      $display("Regression FAIL");
      $finish;
   end
endmodule
